[hw/rtl/pfcs_pkg.sv]
// Shared types, codes and the frequency decode function for the PLL frequency
// change sequencer. No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps

package pfcs_pkg;

	localparam int OSC_MHZ = 24;

	// Divider width: target (12 bits) plus half a step still fits in 13 bits
	localparam int DIV_W = 13;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int STEP_W = 7;
	localparam int N_LADDER_MAX = 32;

	// Reciprocal of three, exact for 16-bit dividends after a shift by 17
	localparam logic [16:0] DIV3_RECIP = 17'd43691;

	localparam logic [1:0] SRC_OSC24 = 2'd1;
	localparam logic [1:0] SRC_PLL = 2'd2;

	localparam logic [1:0] RST_FACTOR_K = 2'd3;
	localparam logic [1:0] RST_FACTOR_M = 2'd1;
	localparam logic [1:0] RST_FACTOR_P = 2'd0;
	localparam logic [11:0] RST_STOCK_MHZ = 12'd1008;
	localparam logic [11:0] RST_SAFE_MHZ = 12'd1248;
	localparam logic [11:0] RST_HARD_MHZ = 12'd1440;
	localparam logic [19:0] RST_TIMEOUT = 20'd100000;
	localparam logic [4:0] RST_PLL_N = 5'd20;

	typedef enum logic [2:0] {
		REG_FACTOR_K = 3'd0,
		REG_FACTOR_M = 3'd1,
		REG_FACTOR_P = 3'd2,
		REG_STOCK = 3'd3,
		REG_SAFE_MAX = 3'd4,
		REG_HARD_MAX = 3'd5,
		REG_TIMEOUT = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		STS_IDLE = 4'd0,
		STS_STARTED = 4'd1,
		STS_BUSY = 4'd2,
		STS_DONE = 4'd3,
		STS_ALREADY = 4'd4,
		STS_ZERO_STEP = 4'd5,
		STS_BELOW_STOCK = 4'd6,
		STS_ABOVE_SAFE = 4'd7,
		STS_ABOVE_HARD = 4'd8,
		STS_ROLLED_BACK = 4'd9,
		STS_MISMATCH = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LOCK = 2'd1,
		PH_ROLLBACK = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV,
		ST_MUL,
		ST_CHECK,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic cap;
		logic tick_apply;
		logic early_reject;
		logic div_start;
		logic mul_load;
		logic check_apply;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic busy;
		logic step_zero;
		logic div_done;
		logic out_full;
	} dp_stat_t;

	// 24*(N+1)*(K+1) / ((M+1)*2^P); floor of floor is the floor of the product
	function automatic logic [11:0] decode_mhz(logic [4:0] n, logic [1:0] k,
			logic [1:0] m, logic [1:0] p);
		logic [5:0] n1;
		logic [2:0] k1;
		logic [8:0] nk;
		logic [11:0] prod;
		logic [28:0] prod3;
		logic [11:0] q1;
		n1 = {1'b0, n} + 6'd1;
		k1 = {1'b0, k} + 3'd1;
		nk = 9'(n1 * k1);
		prod = 12'({3'b000, nk} * 12'(OSC_MHZ));
		prod3 = 29'(prod) * 29'(DIV3_RECIP);
		case (m)
			2'd0: q1 = prod;
			2'd1: q1 = prod >> 1;
			2'd2: q1 = 12'(prod3 >> 17);
			default: q1 = prod >> 2;
		endcase
		return q1 >> p;
	endfunction

endpackage

[hw/rtl/pll_frequency_change_sequencer.sv]
// Top level of the PLL frequency change sequencer: controller plus datapath.
// Depends on pfcs_pkg, pfcs_ctrl, pfcs_datapath (which holds pfcs_div).
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  tuser: mode; tdata: target_mhz, force_req, pll_locked
// m_*       out        m_tvalid / m_tready  tdata: status, factor_n, clock_source, current_mhz,
//                                           busy_res
// cfg_*     in         cfg_we               cfg_index selects the register, cfg_data the value
//
// A tick item, or a set request dropped as busy or zero step, goes from the decide state
// straight to emit; a set request that reaches the snap first passes the divide, multiply
// and check states, the restoring divider taking its thirteen quotient bits in turn. One
// item is worked at a time; the next is taken once the controller is idle.
// Reset is asynchronous and restores stock factors and the PLL source; no clearing pass.
// A result waits in the output register while m_tready is low; the controller holds the
// following result until that register is free and takes no new item meanwhile.

module pll_frequency_change_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] target_mhz, [12] force_req, [13] pll_locked
	input  logic        s_tuser,   // [0] mode: set request or tick
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] status, [8:4] factor_n, [10:9] clock_source,
	                               // [22:11] current_mhz, [23] busy_res
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	// commands from the controller, status back from the datapath
	pfcs_pkg::ctrl_cmd_t cmd;
	pfcs_pkg::dp_stat_t stat;

	// sequence capture, snap, check and result emission
	pfcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers, PLL state, divider and output register
	pfcs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

[hw/rtl/pfcs_div.sv]
// Restoring divider, one quotient bit per cycle, for snapping a target to the step.
// Depends on pfcs_pkg for widths.
`timescale 1ns / 1ps

module pfcs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pfcs_pkg::DIV_W-1:0]      dividend,
	input  logic [pfcs_pkg::STEP_W-1:0]     divisor,
	output logic                            done,
	output logic [pfcs_pkg::DIV_W-1:0]      quotient
);

	logic [pfcs_pkg::STEP_W-1:0] rem_q;
	logic [pfcs_pkg::DIV_W-1:0] quo_q;
	logic [pfcs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic run_q;
	logic done_q;
	logic [pfcs_pkg::STEP_W-1:0] div_q;
	logic [pfcs_pkg::STEP_W:0] trial;
	logic ge;
	logic [pfcs_pkg::STEP_W:0] diff;

	assign trial = {rem_q, quo_q[pfcs_pkg::DIV_W-1]};
	assign ge = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= pfcs_pkg::DIV_CNT_W'(pfcs_pkg::DIV_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[pfcs_pkg::STEP_W-1:0] : trial[pfcs_pkg::STEP_W-1:0];
			quo_q <= {quo_q[pfcs_pkg::DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> run_q && !done_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !run_q)
		else $error("divider done while still running");

endmodule

[hw/rtl/pfcs_ctrl.sv]
// Controller state machine: sequences capture, snap, check, tick update and result.
// Depends on pfcs_pkg for states, command and status structs.
`timescale 1ns / 1ps

module pfcs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  pfcs_pkg::dp_stat_t    stat,
	output pfcs_pkg::ctrl_cmd_t   cmd
);

	pfcs_pkg::ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pfcs_pkg::ST_IDLE: begin
				if (s_tvalid) state_nx = pfcs_pkg::ST_DECIDE;
			end
			pfcs_pkg::ST_DECIDE: begin
				if (stat.is_tick || stat.busy || stat.step_zero) begin
					state_nx = pfcs_pkg::ST_EMIT;
				end else begin
					state_nx = pfcs_pkg::ST_DIV;
				end
			end
			pfcs_pkg::ST_DIV: begin
				if (stat.div_done) state_nx = pfcs_pkg::ST_MUL;
			end
			pfcs_pkg::ST_MUL: state_nx = pfcs_pkg::ST_CHECK;
			pfcs_pkg::ST_CHECK: state_nx = pfcs_pkg::ST_EMIT;
			pfcs_pkg::ST_EMIT: begin
				if (!stat.out_full) state_nx = pfcs_pkg::ST_IDLE;
			end
			default: state_nx = pfcs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			pfcs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.cap = s_tvalid;
			end
			pfcs_pkg::ST_DECIDE: begin
				if (stat.is_tick) begin
					cmd.tick_apply = 1'b1;
				end else if (stat.busy || stat.step_zero) begin
					cmd.early_reject = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			pfcs_pkg::ST_MUL: cmd.mul_load = 1'b1;
			pfcs_pkg::ST_CHECK: cmd.check_apply = 1'b1;
			pfcs_pkg::ST_EMIT: cmd.out_load = !stat.out_full;
			default: cmd = '0;
		endcase
	end

endmodule

[hw/rtl/pfcs_datapath.sv]
// Datapath: configuration registers, PLL state, snap arithmetic and result register.
// Depends on pfcs_pkg and instantiates pfcs_div.
`timescale 1ns / 1ps

module pfcs_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [19:0]           cfg_data,
	input  logic [15:0]           s_tdata,
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,
	input  pfcs_pkg::ctrl_cmd_t   cmd,
	output pfcs_pkg::dp_stat_t    stat
);

	// configuration
	logic [1:0] k_q, m_q, p_q;
	logic [11:0] stock_q, safe_q, hard_q;
	logic [19:0] timeout_q;

	// captured item
	logic mode_q, force_q, locked_q;
	logic [11:0] target_q;

	// sequencer state
	logic [4:0] pll_n_q, saved_n_q;
	logic [1:0] src_q, saved_src_q;
	pfcs_pkg::phase_t phase_q;
	logic [19:0] wait_q;
	logic [11:0] snap_q;

	// snap arithmetic
	logic [5:0] n_q;
	logic [11:0] mhz_q;
	pfcs_pkg::status_t res_q;

	// result register
	logic out_valid_q;
	logic [3:0] o_status_q;
	logic [4:0] o_n_q;
	logic [1:0] o_src_q;
	logic [11:0] o_mhz_q;
	logic o_busy_q;

	logic [11:0] step_full;
	logic [pfcs_pkg::STEP_W-1:0] step;
	logic [11:0] cur_mhz;
	logic [pfcs_pkg::DIV_W-1:0] dividend;
	logic div_done;
	logic [pfcs_pkg::DIV_W-1:0] quo;
	logic [5:0] n_clamp;
	logic [19:0] wait_inc;
	logic timed_out;
	logic busy;

	assign step_full = pfcs_pkg::decode_mhz(5'd0, k_q, m_q, p_q);
	assign step = step_full[pfcs_pkg::STEP_W-1:0];
	assign cur_mhz = pfcs_pkg::decode_mhz(pll_n_q, k_q, m_q, p_q);
	assign dividend = pfcs_pkg::DIV_W'(target_q) + pfcs_pkg::DIV_W'(step >> 1);
	assign busy = (phase_q == pfcs_pkg::PH_LOCK) || (phase_q == pfcs_pkg::PH_ROLLBACK);
	assign wait_inc = wait_q + 20'd1;
	assign timed_out = wait_inc >= timeout_q;

	always_comb begin
		if (quo == '0) begin
			n_clamp = 6'd1;
		end else if (quo > pfcs_pkg::DIV_W'(pfcs_pkg::N_LADDER_MAX)) begin
			n_clamp = 6'(pfcs_pkg::N_LADDER_MAX);
		end else begin
			n_clamp = quo[5:0];
		end
	end

	pfcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (step),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= pfcs_pkg::RST_FACTOR_K;
			m_q <= pfcs_pkg::RST_FACTOR_M;
			p_q <= pfcs_pkg::RST_FACTOR_P;
			stock_q <= pfcs_pkg::RST_STOCK_MHZ;
			safe_q <= pfcs_pkg::RST_SAFE_MHZ;
			hard_q <= pfcs_pkg::RST_HARD_MHZ;
			timeout_q <= pfcs_pkg::RST_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index)
				pfcs_pkg::REG_FACTOR_K: k_q <= cfg_data[1:0];
				pfcs_pkg::REG_FACTOR_M: m_q <= cfg_data[1:0];
				pfcs_pkg::REG_FACTOR_P: p_q <= cfg_data[1:0];
				pfcs_pkg::REG_STOCK: stock_q <= cfg_data[11:0];
				pfcs_pkg::REG_SAFE_MAX: safe_q <= cfg_data[11:0];
				pfcs_pkg::REG_HARD_MAX: hard_q <= cfg_data[11:0];
				pfcs_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture and snap arithmetic
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			mode_q <= s_tuser;
			target_q <= s_tdata[11:0];
			force_q <= s_tdata[12];
			locked_q <= s_tdata[13];
		end
		if (cmd.mul_load) begin
			n_q <= n_clamp;
			mhz_q <= 12'({6'b0, step} * {7'b0, n_clamp});
		end
	end

	// sequencer state; saved values and the snapped frequency are payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pll_n_q <= pfcs_pkg::RST_PLL_N;
			src_q <= pfcs_pkg::SRC_PLL;
			phase_q <= pfcs_pkg::PH_IDLE;
			wait_q <= '0;
			res_q <= pfcs_pkg::STS_IDLE;
		end else begin
			if (cmd.early_reject) begin
				res_q <= busy ? pfcs_pkg::STS_BUSY : pfcs_pkg::STS_ZERO_STEP;
			end
			if (cmd.check_apply) begin
				if (mhz_q < stock_q) begin
					res_q <= pfcs_pkg::STS_BELOW_STOCK;
				end else if (mhz_q > safe_q && !force_q) begin
					res_q <= pfcs_pkg::STS_ABOVE_SAFE;
				end else if (mhz_q > hard_q) begin
					res_q <= pfcs_pkg::STS_ABOVE_HARD;
				end else if (mhz_q == cur_mhz) begin
					res_q <= pfcs_pkg::STS_ALREADY;
				end else begin
					src_q <= pfcs_pkg::SRC_OSC24;
					pll_n_q <= 5'(n_q - 6'd1);
					wait_q <= '0;
					phase_q <= pfcs_pkg::PH_LOCK;
					res_q <= pfcs_pkg::STS_STARTED;
				end
			end
			if (cmd.tick_apply) begin
				case (phase_q)
					pfcs_pkg::PH_LOCK: begin
						if (locked_q) begin
							src_q <= pfcs_pkg::SRC_PLL;
							phase_q <= pfcs_pkg::PH_IDLE;
							wait_q <= '0;
							res_q <= (cur_mhz == snap_q) ? pfcs_pkg::STS_DONE
								: pfcs_pkg::STS_MISMATCH;
						end else begin
							res_q <= pfcs_pkg::STS_STARTED;
							if (timed_out) begin
								pll_n_q <= saved_n_q;
								wait_q <= '0;
								phase_q <= pfcs_pkg::PH_ROLLBACK;
							end else begin
								wait_q <= wait_inc;
							end
						end
					end
					pfcs_pkg::PH_ROLLBACK: begin
						if (locked_q || timed_out) begin
							src_q <= saved_src_q;
							phase_q <= pfcs_pkg::PH_IDLE;
							wait_q <= '0;
							res_q <= pfcs_pkg::STS_ROLLED_BACK;
						end else begin
							wait_q <= wait_inc;
							res_q <= pfcs_pkg::STS_STARTED;
						end
					end
					default: begin
						phase_q <= pfcs_pkg::PH_IDLE;
						res_q <= pfcs_pkg::STS_IDLE;
					end
				endcase
			end
		end
	end

	// take the old setting at each check, so it is at hand when a change starts
	always_ff @(posedge clk) begin
		if (cmd.check_apply) begin
			saved_n_q <= pll_n_q;
			saved_src_q <= src_q;
			snap_q <= mhz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_status_q <= res_q;
			o_n_q <= pll_n_q;
			o_src_q <= src_q;
			o_mhz_q <= cur_mhz;
			o_busy_q <= busy;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {o_busy_q, o_mhz_q, o_src_q, o_n_q, o_status_q};

	assign stat.is_tick = mode_q;
	assign stat.busy = busy;
	assign stat.step_zero = (step == '0);
	assign stat.div_done = div_done;
	assign stat.out_full = out_valid_q && !m_tready;

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != pfcs_pkg::PH_IDLE) |-> (src_q == pfcs_pkg::SRC_OSC24))
		else $error("sequence active while CPU not on the 24 MHz oscillator");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == pfcs_pkg::PH_IDLE) |-> (wait_q == '0))
		else $error("lock wait counter left running while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd.out_load)
		else $error("result overwritten before it was taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check_apply |-> (phase_q == pfcs_pkg::PH_IDLE))
		else $error("frequency change checked while a sequence is active");

endmodule

[dv/pfcs_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the PLL frequency change sequencer: watches the s_*, m_* and cfg_* ports,
// predicts one result per accepted item and compares it field by field. Uses pfcs_pkg.

module pfcs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] target_mhz, [12] force_req, [13] pll_locked
	input  logic        s_tuser,   // [0] mode: set request or tick
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [3:0] status, [8:4] factor_n, [10:9] clock_source,
	                               // [22:11] current_mhz, [23] busy_res
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          items_seen,
	output int          results_seen,
	output int          locks_done,
	output int          rollbacks
);

	typedef struct packed {
		pfcs_pkg::status_t status;
		logic [4:0]        factor_n;
		logic [1:0]        clock_source;
		logic [11:0]       current_mhz;
		logic              busy;
	} freq_result_t;

	logic [1:0]        k_cfg, m_cfg, p_cfg;
	logic [11:0]       stock_cfg, safe_cfg, hard_cfg;
	logic [19:0]       timeout_cfg;
	logic [4:0]        n_now, n_saved;
	logic [1:0]        src_now, src_saved;
	pfcs_pkg::phase_t  seq_phase;
	logic [19:0]       wait_cnt;
	logic [11:0]       snapped;

	freq_result_t expected_results[$];
	int errors, n_items, n_results, n_locks, n_rollbacks;

	function automatic logic [11:0] freq_of(input logic [4:0] n);
		int unsigned num, den;
		num = pfcs_pkg::OSC_MHZ * (int'(n) + 1) * (int'(k_cfg) + 1);
		den = (int'(m_cfg) + 1) << p_cfg;
		return 12'(num / den);
	endfunction

	function automatic pfcs_pkg::status_t request_change(input logic [11:0] want,
			input logic allow_over);
		int unsigned den, stp, mult, mhz;
		if (seq_phase == pfcs_pkg::PH_LOCK || seq_phase == pfcs_pkg::PH_ROLLBACK)
			return pfcs_pkg::STS_BUSY;
		den = (int'(m_cfg) + 1) << p_cfg;
		stp = pfcs_pkg::OSC_MHZ * (int'(k_cfg) + 1) / den;
		if (stp == 0)
			return pfcs_pkg::STS_ZERO_STEP;
		// snap to the nearest step, multiplier limited to 1..32
		mult = (int'(want) + stp / 2) / stp;
		if (mult == 0)
			mult = 1;
		if (mult > pfcs_pkg::N_LADDER_MAX)
			mult = pfcs_pkg::N_LADDER_MAX;
		mhz = stp * mult;
		if (mhz < stock_cfg)
			return pfcs_pkg::STS_BELOW_STOCK;
		if (mhz > safe_cfg && !allow_over)
			return pfcs_pkg::STS_ABOVE_SAFE;
		if (mhz > hard_cfg)
			return pfcs_pkg::STS_ABOVE_HARD;
		if (mhz == freq_of(n_now))
			return pfcs_pkg::STS_ALREADY;
		n_saved = n_now;
		src_saved = src_now;
		src_now = pfcs_pkg::SRC_OSC24;
		n_now = 5'(mult - 1);
		snapped = 12'(mhz);
		wait_cnt = '0;
		seq_phase = pfcs_pkg::PH_LOCK;
		return pfcs_pkg::STS_STARTED;
	endfunction

	function automatic logic timed_out();
		wait_cnt = wait_cnt + 20'd1;
		return wait_cnt >= timeout_cfg;
	endfunction

	function automatic pfcs_pkg::status_t tick_sequencer(input logic locked);
		if (seq_phase == pfcs_pkg::PH_LOCK) begin
			if (locked) begin
				src_now = pfcs_pkg::SRC_PLL;
				seq_phase = pfcs_pkg::PH_IDLE;
				wait_cnt = '0;
				// factors changed under the wait show up as a readback mismatch
				return (freq_of(n_now) == snapped) ? pfcs_pkg::STS_DONE : pfcs_pkg::STS_MISMATCH;
			end
			if (timed_out()) begin
				n_now = n_saved;
				wait_cnt = '0;
				seq_phase = pfcs_pkg::PH_ROLLBACK;
			end
			return pfcs_pkg::STS_STARTED;
		end
		if (seq_phase == pfcs_pkg::PH_ROLLBACK) begin
			if (locked || timed_out()) begin
				src_now = src_saved;
				seq_phase = pfcs_pkg::PH_IDLE;
				wait_cnt = '0;
				return pfcs_pkg::STS_ROLLED_BACK;
			end
			return pfcs_pkg::STS_STARTED;
		end
		seq_phase = pfcs_pkg::PH_IDLE;
		return pfcs_pkg::STS_IDLE;
	endfunction

	function automatic freq_result_t predict_item(input logic is_tick, input logic [15:0] data);
		freq_result_t r;
		if (is_tick)
			r.status = tick_sequencer(data[13]);
		else
			r.status = request_change(data[11:0], data[12]);
		r.factor_n = n_now;
		r.clock_source = src_now;
		r.current_mhz = freq_of(n_now);
		r.busy = (seq_phase == pfcs_pkg::PH_LOCK || seq_phase == pfcs_pkg::PH_ROLLBACK);
		return r;
	endfunction

	function automatic void check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		freq_result_t want;
		if (!arst_n) begin
			k_cfg = pfcs_pkg::RST_FACTOR_K;
			m_cfg = pfcs_pkg::RST_FACTOR_M;
			p_cfg = pfcs_pkg::RST_FACTOR_P;
			stock_cfg = pfcs_pkg::RST_STOCK_MHZ;
			safe_cfg = pfcs_pkg::RST_SAFE_MHZ;
			hard_cfg = pfcs_pkg::RST_HARD_MHZ;
			timeout_cfg = pfcs_pkg::RST_TIMEOUT;
			n_now = pfcs_pkg::RST_PLL_N;
			src_now = pfcs_pkg::SRC_PLL;
			n_saved = '0;
			src_saved = '0;
			seq_phase = pfcs_pkg::PH_IDLE;
			wait_cnt = '0;
			snapped = '0;
			expected_results.delete();
			errors = 0;
			n_items = 0;
			n_results = 0;
			n_locks = 0;
			n_rollbacks = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				pfcs_pkg::REG_FACTOR_K: k_cfg = cfg_data[1:0];
				pfcs_pkg::REG_FACTOR_M: m_cfg = cfg_data[1:0];
				pfcs_pkg::REG_FACTOR_P: p_cfg = cfg_data[1:0];
				pfcs_pkg::REG_STOCK: stock_cfg = cfg_data[11:0];
				pfcs_pkg::REG_SAFE_MAX: safe_cfg = cfg_data[11:0];
				pfcs_pkg::REG_HARD_MAX: hard_cfg = cfg_data[11:0];
				pfcs_pkg::REG_TIMEOUT: timeout_cfg = cfg_data;
				default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_item(s_tuser, s_tdata));
				n_items++;
			end
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$error("result %h arrived with no item outstanding", m_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, m_tdata[3:0]);
					check_field("factor_n", want.factor_n, m_tdata[8:4]);
					check_field("clock_source", want.clock_source, m_tdata[10:9]);
					check_field("current_mhz", want.current_mhz, m_tdata[22:11]);
					check_field("busy_res", want.busy, m_tdata[23]);
					if (want.status == pfcs_pkg::STS_DONE)
						n_locks++;
					if (want.status == pfcs_pkg::STS_ROLLED_BACK)
						n_rollbacks++;
				end
			end
		end
		fail_count <= errors;
		pending <= expected_results.size();
		items_seen <= n_items;
		results_seen <= n_results;
		locks_done <= n_locks;
		rollbacks <= n_rollbacks;
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the testbench for pll_frequency_change_sequencer: clock, reset, stimulus and verdict.
// Depends on pfcs_pkg, the block's RTL and pfcs_checker, which does all the comparing.

module tb_top;

	localparam int HOLD_CYCLES = 400;     // long receiver hold-off, fills the block up
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [11:0] target_mhz, [12] force_req, [13] pll_locked
	logic        s_tuser;   // [0] mode: set request or tick
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [3:0] status, [8:4] factor_n, [10:9] clock_source,
	                        // [22:11] current_mhz, [23] busy_res
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [19:0] cfg_data;

	int fail_count, pending, items_seen, results_seen, locks_done, rollbacks;

	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int sent = 0;

	pll_frequency_change_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pfcs_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.items_seen   (items_seen),
		.results_seen (results_seen),
		.locks_done   (locks_done),
		.rollbacks    (rollbacks)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs on either channel
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Result side: random stalls, plus a long hold-off whenever the stimulus asks for one
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked > holds_served) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				holds_served++;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	// Offer one item and hold it until accepted; tvalid stays high for a back-to-back item
	task automatic send_item(input logic is_tick, input logic [11:0] target,
			input logic allow_over, input logic locked);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= is_tick;
		s_tdata <= {2'b00, locked, allow_over, target};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Drop tvalid and wait until every outstanding result is back and the block is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Program a full register set, then run change sequences mixed with noise.
	// Most sequences are a set request aimed near the legal window followed by a
	// burst of ticks that lock now and then, so locks, timeouts and rollbacks all occur.
	task automatic run_phase(input int k, input int m, input int p, input int stock,
			input int safe, input int hard, input int timeout, input int idle_pct,
			input int stall_pct, input bit hold_off, input int count);
		int stp, lo, hi, stop;
		write_reg(pfcs_pkg::REG_FACTOR_K, 20'(k));
		write_reg(pfcs_pkg::REG_FACTOR_M, 20'(m));
		write_reg(pfcs_pkg::REG_FACTOR_P, 20'(p));
		write_reg(pfcs_pkg::REG_STOCK, 20'(stock));
		write_reg(pfcs_pkg::REG_SAFE_MAX, 20'(safe));
		write_reg(pfcs_pkg::REG_HARD_MAX, 20'(hard));
		write_reg(pfcs_pkg::REG_TIMEOUT, 20'(timeout));
		snd_idle_pct = idle_pct;
		rcv_stall_pct = stall_pct;
		if (hold_off)
			holds_asked++;
		stp = pfcs_pkg::OSC_MHZ * (k + 1) / ((m + 1) << p);
		lo = (stock > 2 * stp) ? stock - 2 * stp : 0;
		hi = (hard + 2 * stp > 4095) ? 4095 : hard + 2 * stp;
		stop = sent + count;
		while (sent < stop) begin
			if ($urandom_range(99) < 80) begin
				send_item(1'b0, 12'($urandom_range(lo, hi)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				repeat ($urandom_range(1, 8))
					send_item(1'b1, 12'($urandom), 1'($urandom_range(1)),
						$urandom_range(99) < 20);
			end else begin
				send_item(1'($urandom_range(1)), 12'($urandom), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on stock factors: step is 48 MHz, the PLL sits at 1008
		send_item(1'b1, 12'd0, 1'b0, 1'b0);        // tick while idle
		send_item(1'b0, 12'd1008, 1'b0, 1'b0);     // already at the target
		send_item(1'b0, 12'd960, 1'b0, 1'b0);      // below stock
		send_item(1'b0, 12'd1300, 1'b0, 1'b0);     // above safe without force
		send_item(1'b0, 12'd1300, 1'b1, 1'b0);     // forced, starts a change to 1296
		send_item(1'b0, 12'd1100, 1'b0, 1'b1);     // set while busy is ignored
		send_item(1'b1, 12'hFFF, 1'b1, 1'b1);      // lock arrives, change done
		send_item(1'b0, 12'hFFF, 1'b1, 1'b0);      // multiplier clamps at 32, above hard
		send_item(1'b0, 12'd0, 1'b0, 1'b1);        // multiplier clamps at 1, below stock

		// Lock timeout: rollback that itself times out, then one that ends on lock
		write_reg(pfcs_pkg::REG_TIMEOUT, 20'd2);
		send_item(1'b0, 12'd1104, 1'b0, 1'b0);
		repeat (4) send_item(1'b1, 12'd0, 1'b0, 1'b0);
		send_item(1'b0, 12'd1152, 1'b0, 1'b0);
		repeat (2) send_item(1'b1, 12'd0, 1'b0, 1'b0);
		send_item(1'b1, 12'd0, 1'b0, 1'b1);

		// A zero timeout acts like one tick; a write past the last register is dropped
		write_reg(pfcs_pkg::REG_TIMEOUT, 20'd0);
		write_reg(CFG_UNUSED_IDX, 20'hFFFFF);
		send_item(1'b0, 12'd1200, 1'b0, 1'b0);
		repeat (2) send_item(1'b1, 12'd0, 1'b0, 1'b0);

		// Readback mismatch: change K while the lock wait is open
		send_item(1'b0, 12'd1248, 1'b0, 1'b0);
		write_reg(pfcs_pkg::REG_FACTOR_K, 20'd2);
		send_item(1'b1, 12'd0, 1'b0, 1'b1);

		// Zero step: K=0 with the largest divider
		write_reg(pfcs_pkg::REG_FACTOR_K, 20'd0);
		write_reg(pfcs_pkg::REG_FACTOR_M, 20'd3);
		write_reg(pfcs_pkg::REG_FACTOR_P, 20'd3);
		send_item(1'b0, 12'd500, 1'b1, 1'b0);

		// Random part: one register set per traffic pattern
		run_phase(3, 1, 0, 1008, 1248, 1440, 3, 0, 0, 1'b1, 90);
		run_phase(0, 0, 0, 0, 4095, 4095, 1, 77, 0, 1'b0, 90);
		run_phase(3, 3, 3, 24, 60, 90, 5, 0, 77, 1'b0, 80);
		run_phase(1, 2, 1, 100, 200, 256, 4, 18, 18, 1'b0, 80);
		run_phase(2, 0, 2, 200, 400, 500, 1048575, 0, 0, 1'b0, 60);
		run_phase(3, 0, 0, 4095, 0, 0, 1, 18, 18, 1'b0, 20);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items driven, %0d results checked: %0d changes locked, %0d rolled back",
			items_seen, results_seen, locks_done, rollbacks);
		$display("swept factors, limits and lock timeouts across their extremes under gaps, ",
			"stalls and a long output hold-off");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[pll_frequency_change_sequencer.f]
hw/rtl/pfcs_pkg.sv
hw/rtl/pfcs_div.sv
hw/rtl/pfcs_ctrl.sv
hw/rtl/pfcs_datapath.sv
hw/rtl/pll_frequency_change_sequencer.sv
dv/pfcs_checker.sv
dv/tb_top.sv
